// ----- hw/rtl/pvc_pkg.sv -----
`timescale 1ns / 1ps

package pvc_pkg;

    // Field widths of a pileup column and of a report.
    localparam int COUNT_W  = 16;
    localparam int REF_W    = 3;
    localparam int DEPTH_W  = 16;
    localparam int POS_W    = 24;
    localparam int CALL_W   = 3;
    localparam int INS_W    = 2;

    // Number of candidates in the consensus call and in the insertion call.
    localparam int NUM_BASE = 5;
    localparam int NUM_INS  = 4;

    localparam int WINDOW_DEF = 5;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 56;

    localparam logic [CALL_W-1:0] CALL_DEL = 3'd4;
    localparam logic [POS_W-1:0]  POS_MAX  = 24'hFFFFFF;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DROP,
        ST_FLUSH
    } state_t;

    // One column waiting for its report.
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [CALL_W-1:0]  called;
        logic [INS_W-1:0]   ins_base;
        logic [COUNT_W-1:0] ins_cnt;
        logic [REF_W-1:0]   ref_b;
        logic [DEPTH_W-1:0] depth;
    } rec_t;

endpackage

// ----- hw/rtl/pvc_lane.sv -----
`timescale 1ns / 1ps

// One candidate lane: high when its count is the first maximum of the set.
module pvc_lane #(
    parameter int N   = 5,
    parameter int IDX = 0
) (
    input  logic [N-1:0][pvc_pkg::COUNT_W-1:0] vals,
    output logic                               win
);

    always_comb begin
        win = 1'b1;
        for (int k = 0; k < N; k++) begin
            if (k < IDX) begin
                win = win & (vals[IDX] > vals[k]);
            end else if (k > IDX) begin
                win = win & (vals[IDX] >= vals[k]);
            end
        end
    end

endmodule

// ----- hw/rtl/pvc_argmax.sv -----
`timescale 1ns / 1ps

// Runs one lane per candidate and merges the one-hot lane results into
// the winning index and its count.
module pvc_argmax #(
    parameter int N = 5
) (
    input  logic [N-1:0][pvc_pkg::COUNT_W-1:0] vals,
    output logic [$clog2(N)-1:0]               idx,
    output logic [pvc_pkg::COUNT_W-1:0]        max_val
);

    localparam int IDX_W = $clog2(N);

    logic [N-1:0] win;

    for (genvar g = 0; g < N; g++) begin : g_lane
        pvc_lane #(
            .N   (N),
            .IDX (g)
        ) u_lane (
            .vals (vals),
            .win  (win[g])
        );
    end

    always_comb begin
        idx     = '0;
        max_val = '0;
        for (int k = 0; k < N; k++) begin
            if (win[k]) begin
                idx     = idx | IDX_W'(k);
                max_val = max_val | vals[k];
            end
        end
    end

endmodule

// ----- hw/rtl/pileup_variant_caller_unit.sv -----
`timescale 1ns / 1ps

// Pileup variant caller. Pileup columns of one contig arrive in order on the
// slave stream, one column per transaction, with s_tlast marking the final
// column. For each column the block calls the consensus (first maximum of
// A, C, G, T and deletion), flags SNVs and deletions, and flags an insertion
// when twice the best insertion count exceeds the mean winning count over
// the columns [i-WINDOW, i+WINDOW), clipped to the contig; the test is exact
// integer cross-multiplication. A report leaves on the master stream WINDOW-1
// columns after its column. While the contig runs, the block takes one
// column per cycle as long as the output register is free: the consensus
// and insertion lanes finish in the accept cycle, and the report is formed
// from the pending queue afterwards while the next column is being taken.
// The final column starts a flush: first a trim of up to 2*WINDOW-1 of the
// oldest columns off the window ring, then one report per cycle, whenever
// the single output register is free, for the up to WINDOW pending columns.
// No column is accepted during the flush; after the last report (m_tlast
// high) the block is back in its reset state for the next contig.
module pileup_variant_caller_unit #(
    parameter int WINDOW = pvc_pkg::WINDOW_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // s_tdata, from the lowest bit up: count_a, count_c, count_g, count_t,
    // count_gap, ins_a, ins_c, ins_g, ins_t (16 bits each), ref_base (3),
    // depth (16), zero fill (5). s_tlast carries final_column.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pvc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,

    // m_tdata, from the lowest bit up: position (24), called_base (3),
    // is_snv (1), is_deletion (1), is_insertion (1), inserted_base (2),
    // ref_base_out (3), depth_out (16), zero fill (5).
    // m_tlast carries last_report.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pvc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    localparam int CW     = pvc_pkg::COUNT_W;
    localparam int RING   = 2 * WINDOW;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int LEN_W  = $clog2(RING + 1);
    localparam int SUM_W  = CW + $clog2(RING);
    localparam int DROP_W = $clog2(RING);
    localparam int PROD_W = CW + LEN_W;
    localparam int CMP_W  = PROD_W + 1;

    // ------------------------------------------------------------------
    // Input unpacking and the two argmax lane groups.
    // ------------------------------------------------------------------
    logic [pvc_pkg::NUM_BASE-1:0][CW-1:0] base_vals;
    logic [pvc_pkg::NUM_INS-1:0][CW-1:0]  ins_vals;
    logic [pvc_pkg::REF_W-1:0]            in_ref;
    logic [pvc_pkg::DEPTH_W-1:0]          in_depth;
    logic [pvc_pkg::CALL_W-1:0]           call_idx;
    logic [CW-1:0]                        call_best;
    logic [pvc_pkg::INS_W-1:0]            ins_idx;
    logic [CW-1:0]                        ins_best;

    always_comb begin
        for (int k = 0; k < pvc_pkg::NUM_BASE; k++) begin
            base_vals[k] = s_tdata[CW*k +: CW];
        end
        for (int k = 0; k < pvc_pkg::NUM_INS; k++) begin
            ins_vals[k] = s_tdata[CW*(pvc_pkg::NUM_BASE + k) +: CW];
        end
    end

    assign in_ref   = s_tdata[144 +: pvc_pkg::REF_W];
    assign in_depth = s_tdata[147 +: pvc_pkg::DEPTH_W];

    pvc_argmax #(
        .N (pvc_pkg::NUM_BASE)
    ) u_call (
        .vals    (base_vals),
        .idx     (call_idx),
        .max_val (call_best)
    );

    pvc_argmax #(
        .N (pvc_pkg::NUM_INS)
    ) u_ins (
        .vals    (ins_vals),
        .idx     (ins_idx),
        .max_val (ins_best)
    );

    // ------------------------------------------------------------------
    // State.
    // ------------------------------------------------------------------
    pvc_pkg::state_t      state_reg, state_next;
    // Winning counts of the last 2*WINDOW columns as a shift line: index 0
    // is the newest column, index RING-1 the oldest. Columns that do not
    // exist read as zero, so the running sum is the clipped window sum.
    logic [CW-1:0]        win_reg [RING];
    logic [CW-1:0]        win_next [RING];
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [pvc_pkg::POS_W-1:0] col_reg, col_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     pend_len_reg, pend_len_next;
    // Reports already given in this contig, saturating at WINDOW. It is the
    // number of columns the window reaches back from the reported column.
    logic [CNT_W-1:0]     done_reg, done_next;
    logic [DROP_W-1:0]    drop_reg, drop_next;
    logic                 emit_pend_reg, emit_pend_next;
    pvc_pkg::rec_t        pend_reg [WINDOW];

    logic                 m_valid_reg;
    logic [pvc_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    // ------------------------------------------------------------------
    // Handshake and report formation.
    // ------------------------------------------------------------------
    logic                 out_free;
    logic                 in_acc;
    logic                 emit_run;
    logic                 emit_fl;
    logic                 emit_go;
    logic                 push;
    logic                 shift_zero;
    logic [CNT_W-1:0]     len_eff;
    logic [CNT_W-1:0]     len_after;
    logic [LEN_W-1:0]     drop_full;
    pvc_pkg::rec_t        head_rec;
    pvc_pkg::rec_t        new_rec;
    logic [LEN_W-1:0]     after_len;
    logic [LEN_W-1:0]     win_len;
    logic [PROD_W-1:0]    prod;
    logic [CMP_W-1:0]     lhs;
    logic                 ins_hit;
    logic                 rep_snv;
    logic                 rep_del;
    logic                 rep_last;

    assign out_free = !m_valid_reg || m_tready;
    // A report due from an earlier column is formed once the output register
    // is free; a new column can be taken as long as that report finds the
    // output register free.
    assign s_tready = (state_reg == pvc_pkg::ST_RUN) && (!emit_pend_reg || out_free);
    assign in_acc   = s_tvalid && s_tready;
    assign emit_run = (state_reg == pvc_pkg::ST_RUN) && emit_pend_reg && out_free;
    assign emit_fl  = (state_reg == pvc_pkg::ST_FLUSH) && out_free;
    assign emit_go  = emit_run || emit_fl;

    assign head_rec = pend_reg[head_reg];

    always_comb begin
        new_rec.pos      = col_reg;
        new_rec.called   = call_idx;
        new_rec.ins_base = ins_idx;
        new_rec.ins_cnt  = ins_best;
        new_rec.ref_b    = in_ref;
        new_rec.depth    = in_depth;
    end

    // While the contig runs the window reaches WINDOW columns ahead of the
    // reported one; during the flush it reaches to the final column, which
    // is as many columns as are still pending.
    assign after_len = emit_fl ? LEN_W'(pend_len_reg) : LEN_W'(WINDOW);
    assign win_len   = LEN_W'(done_reg) + after_len;
    assign prod      = PROD_W'(head_rec.ins_cnt) * PROD_W'(win_len);
    assign lhs       = {prod, 1'b0};
    assign ins_hit   = lhs > CMP_W'(sum_reg);
    assign rep_del   = (head_rec.called == pvc_pkg::CALL_DEL);
    assign rep_snv   = !rep_del && (pvc_pkg::REF_W'(head_rec.called) != head_rec.ref_b);
    assign rep_last  = emit_fl && (pend_len_reg == CNT_W'(1));

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        col_next       = col_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        done_next      = done_reg;
        drop_next      = drop_reg;
        emit_pend_next = emit_pend_reg;
        for (int k = 0; k < RING; k++) begin
            win_next[k] = win_reg[k];
        end

        len_eff       = pend_len_reg - CNT_W'(emit_go);
        push          = in_acc && (len_eff < CNT_W'(WINDOW));
        len_after     = len_eff + CNT_W'(push);
        pend_len_next = len_after;

        if (emit_go && (done_reg != CNT_W'(WINDOW))) begin
            done_next = done_reg + CNT_W'(1);
        end

        if (emit_go) begin
            head_next = (head_reg == PTR_W'(WINDOW - 1)) ? '0 : head_reg + PTR_W'(1);
        end
        if (push) begin
            tail_next = (tail_reg == PTR_W'(WINDOW - 1)) ? '0 : tail_reg + PTR_W'(1);
        end

        // A new column enters the line and the oldest leaves it. While
        // trimming, and during the flush once the window start moves, the
        // oldest column leaves without a replacement.
        shift_zero = (state_reg == pvc_pkg::ST_DROP)
                  || (emit_fl && (done_reg == CNT_W'(WINDOW)));
        if (in_acc || shift_zero) begin
            win_next[0] = in_acc ? call_best : '0;
            for (int k = 1; k < RING; k++) begin
                win_next[k] = win_reg[k-1];
            end
            sum_next = sum_reg + (in_acc ? SUM_W'(call_best) : '0)
                     - SUM_W'(win_reg[RING-1]);
        end

        if (in_acc && (col_reg != pvc_pkg::POS_MAX)) begin
            col_next = col_reg + pvc_pkg::POS_W'(1);
        end

        if (in_acc && !s_tlast && (len_after == CNT_W'(WINDOW))) begin
            emit_pend_next = 1'b1;
        end else if (emit_run) begin
            emit_pend_next = 1'b0;
        end

        // Columns at the old end of the line that lie before the window of
        // the first flushed report are trimmed off before the flush.
        drop_full = LEN_W'(RING) - LEN_W'(len_after) - LEN_W'(done_next);

        case (state_reg)
            pvc_pkg::ST_RUN: begin
                if (in_acc && s_tlast) begin
                    drop_next  = DROP_W'(drop_full);
                    state_next = (drop_full == '0) ? pvc_pkg::ST_FLUSH : pvc_pkg::ST_DROP;
                end
            end
            pvc_pkg::ST_DROP: begin
                drop_next = drop_reg - DROP_W'(1);
                if (drop_reg == DROP_W'(1)) begin
                    state_next = pvc_pkg::ST_FLUSH;
                end
            end
            pvc_pkg::ST_FLUSH: begin
                if (rep_last) begin
                    // Back to the reset state for the next contig.
                    state_next    = pvc_pkg::ST_RUN;
                    sum_next      = '0;
                    col_next      = '0;
                    head_next     = '0;
                    tail_next     = '0;
                    pend_len_next = '0;
                    done_next     = '0;
                    for (int k = 0; k < RING; k++) begin
                        win_next[k] = '0;
                    end
                end
            end
            default: begin
                state_next = pvc_pkg::ST_RUN;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pvc_pkg::ST_RUN;
            sum_reg       <= '0;
            col_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            pend_len_reg  <= '0;
            done_reg      <= '0;
            drop_reg      <= '0;
            emit_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int k = 0; k < RING; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            col_reg       <= col_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            pend_len_reg  <= pend_len_next;
            done_reg      <= done_next;
            drop_reg      <= drop_next;
            emit_pend_reg <= emit_pend_next;
            for (int k = 0; k < RING; k++) begin
                win_reg[k] <= win_next[k];
            end
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Pending columns and the report payload carry no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            pend_reg[tail_reg] <= new_rec;
        end
        if (emit_go) begin
            m_data_reg <= {5'd0, head_rec.depth, head_rec.ref_b, head_rec.ins_base,
                           ins_hit, rep_del, rep_snv, head_rec.called, head_rec.pos};
            m_last_reg <= rep_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_len_reg <= CNT_W'(WINDOW)) && (done_reg <= CNT_W'(WINDOW)))
        else $error("pending or reported count beyond the window");

    a_emit_run_only: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_pend_reg |-> (state_reg == pvc_pkg::ST_RUN))
        else $error("running report left pending into the flush");

    a_drop_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pvc_pkg::ST_DROP) |-> (drop_reg != '0))
        else $error("trim phase entered with nothing to trim");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_last |=> ((state_reg == pvc_pkg::ST_RUN) && (sum_reg == '0)
                      && (col_reg == '0) && (pend_len_reg == '0)))
        else $error("flush did not return to the reset state");

endmodule

// ----- verif/tb_pileup_variant_caller_unit.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the pileup variant caller. Pileup columns are
// queued by the stimulus process, driven onto the slave stream by a clocked
// driver, and every accepted column is run through a column-accurate
// consensus and window predictor. The resulting reports are checked, field
// by field and in order, against the transactions seen on the master stream.
module tb_pileup_variant_caller_unit;

    import pvc_pkg::*;

    localparam int WINDOW     = WINDOW_DEF;
    localparam int RING       = 2 * WINDOW;
    localparam int CLK_HALF   = 4;
    localparam int LONG_HOLD  = 120;
    localparam int QUIET_MAX  = 1000;
    localparam int SETTLE     = 3 * WINDOW + 10;

    // One pileup column as the stimulus sees it. The packed arrays put
    // index 0 in the lowest bits, which is also the order on s_tdata.
    typedef struct packed {
        logic                             final_col;
        logic [DEPTH_W-1:0]               depth;
        logic [REF_W-1:0]                 ref_b;
        logic [NUM_INS-1:0][COUNT_W-1:0]  ins;
        logic [NUM_BASE-1:0][COUNT_W-1:0] cnt;
    } column_t;

    // One report. Without last_report the layout matches m_tdata bit for bit, up to the zero fill.
    typedef struct packed {
        logic               last_report;
        logic [DEPTH_W-1:0] depth_out;
        logic [REF_W-1:0]   ref_base_out;
        logic [INS_W-1:0]   inserted_base;
        logic               is_insertion;
        logic               is_deletion;
        logic               is_snv;
        logic [CALL_W-1:0]  called_base;
        logic [POS_W-1:0]   position;
    } report_t;

    // A called column waiting until its window is complete.
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [CALL_W-1:0]  called;
        logic [INS_W-1:0]   ins_base;
        logic [COUNT_W-1:0] ins_cnt;
        logic [REF_W-1:0]   ref_b;
        logic [DEPTH_W-1:0] depth;
        int                 slot;
    } waiting_col_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    pileup_variant_caller_unit #(
        .WINDOW(WINDOW)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Columns waiting to be driven, and reports the block still owes us.
    column_t      col_queue[$];
    report_t      expected_reports[$];

    // Predictor state: ring of winning counts, columns waiting for their
    // report, the next column index and the reports issued in this contig.
    logic [COUNT_W-1:0] win_ring[RING] = '{default: '0};
    waiting_col_t       waiting_cols[$];
    logic [POS_W-1:0]   next_pos = '0;
    int                 ring_wr = 0;
    int                 reports_in_contig = 0;

    // Shared knobs and bookkeeping.
    int      idle_pct = 0;
    int      hold_requests = 0;
    int      err_count = 0;
    int      cols_queued = 0;
    int      cols_accepted = 0;
    int      contigs_sent = 0;
    int      reports_checked = 0;
    int      snv_seen = 0;
    int      del_seen = 0;
    int      ins_seen = 0;
    int      holds_seen = 0;
    column_t cur_col = '0;

    //--------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------

    // Forms the report of one waiting column. The window runs from the
    // reports already issued in this contig back of the column to "after"
    // columns from it, so it is clipped at both ends of the contig.
    task automatic emit_report(waiting_col_t r, int after, logic last);
        report_t         rep;
        int              span;
        int              k;
        longint unsigned win_total;
        longint unsigned lhs;
        span = reports_in_contig + after;
        win_total = 0;
        for (k = 0; k < span; k++) begin
            win_total += win_ring[(r.slot + RING - reports_in_contig + k) % RING];
        end
        lhs = 2 * longint'(r.ins_cnt) * longint'(span);
        rep.position      = r.pos;
        rep.called_base   = r.called;
        rep.is_snv        = (r.called != CALL_DEL) && (r.called != r.ref_b);
        rep.is_deletion   = (r.called == CALL_DEL);
        rep.is_insertion  = (lhs > win_total);
        rep.inserted_base = r.ins_base;
        rep.ref_base_out  = r.ref_b;
        rep.depth_out     = r.depth;
        rep.last_report   = last;
        expected_reports = {expected_reports, rep};
        if (reports_in_contig < WINDOW) begin
            reports_in_contig++;
        end
    endtask

    // Calls one accepted column and queues whatever reports it releases.
    task automatic call_column(column_t col);
        waiting_col_t       r;
        logic [COUNT_W-1:0] best;
        int                 c;
        int                 n;
        best = col.cnt[0];
        r.called = '0;
        for (c = 1; c < NUM_BASE; c++) begin
            if (col.cnt[c] > best) begin
                best = col.cnt[c];
                r.called = CALL_W'(c);
            end
        end
        r.ins_cnt = col.ins[0];
        r.ins_base = '0;
        for (c = 1; c < NUM_INS; c++) begin
            if (col.ins[c] > r.ins_cnt) begin
                r.ins_cnt = col.ins[c];
                r.ins_base = INS_W'(c);
            end
        end
        r.ref_b = col.ref_b;
        r.depth = col.depth;
        r.pos   = next_pos;
        r.slot  = ring_wr;

        win_ring[ring_wr] = best;
        ring_wr = (ring_wr + 1) % RING;
        if (waiting_cols.size() < WINDOW) begin
            waiting_cols = {waiting_cols, r};
        end
        if (next_pos != POS_MAX) begin
            next_pos++;
        end

        if (!col.final_col) begin
            if (waiting_cols.size() == WINDOW) begin
                emit_report(waiting_cols.pop_front(), WINDOW, 1'b0);
            end
        end else begin
            // The final column flushes every waiting column in order, then
            // the block starts over as if just out of reset.
            n = waiting_cols.size();
            for (c = 0; c < n; c++) begin
                emit_report(waiting_cols[c], n - c, (c + 1 == n));
            end
            waiting_cols.delete();
            win_ring = '{default: '0};
            next_pos = '0;
            ring_wr = 0;
            reports_in_contig = 0;
        end
    endtask

    //--------------------------------------------------------------------
    // Slave-side driver
    //--------------------------------------------------------------------

    int send_gap = 0;

    // A column stays on the bus until its transaction completes. Idle bursts
    // start only between transactions.
    always @(posedge aclk) begin
        logic give;
        give = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            send_gap = 0;
        end else if (s_tvalid && !s_tready) begin
            // Still waiting for the block to take the current column.
        end else begin
            if (s_tvalid) begin
                call_column(cur_col);
                cols_accepted++;
            end
            if (send_gap > 0) begin
                send_gap--;
            end else if (col_queue.size() > 0) begin
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                    send_gap = $urandom_range(0, 4);
                end else begin
                    cur_col = col_queue.pop_front();
                    give = 1'b1;
                end
            end
            s_tvalid <= give;
            if (give) begin
                s_tdata <= S_TDATA_W'({cur_col.depth, cur_col.ref_b, cur_col.ins, cur_col.cnt});
                s_tlast <= cur_col.final_col;
            end
        end
    end

    //--------------------------------------------------------------------
    // Master-side monitor and ready control
    //--------------------------------------------------------------------

    int stall_left = 0;
    int hold_left  = 0;

    task automatic check_field(string field, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
            err_count++;
        end
    endtask

    // Each report transaction is compared with the oldest expected report.
    // A long hold-off is started here when the stimulus asks for one, so the
    // block has to back up into its input.
    always @(posedge aclk) begin
        report_t got;
        report_t want;
        logic    rdy;
        rdy = 1'b0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = report_t'({m_tlast, m_tdata[$bits(report_t)-2:0]});
                if (expected_reports.size() == 0) begin
                    $error("report for position %0d arrived with none expected",
                           got.position);
                    err_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("position", want.position, got.position);
                    check_field("called_base", want.called_base, got.called_base);
                    check_field("is_snv", want.is_snv, got.is_snv);
                    check_field("is_deletion", want.is_deletion, got.is_deletion);
                    check_field("is_insertion", want.is_insertion, got.is_insertion);
                    check_field("inserted_base", want.inserted_base, got.inserted_base);
                    check_field("ref_base_out", want.ref_base_out, got.ref_base_out);
                    check_field("depth_out", want.depth_out, got.depth_out);
                    check_field("last_report", want.last_report, got.last_report);
                end
                reports_checked++;
                snv_seen += got.is_snv;
                del_seen += got.is_deletion;
                ins_seen += got.is_insertion;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_requests != holds_seen) begin
                holds_seen++;
                hold_left = LONG_HOLD - 1;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(0, 4);
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    //--------------------------------------------------------------------
    // Watchdog: only counts while there is still work outstanding.
    //--------------------------------------------------------------------

    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (col_queue.size() == 0 && !s_tvalid && expected_reports.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("timeout: no transaction for %0d cycles", QUIET_MAX);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    //--------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------

    function automatic column_t make_column(int a, int c, int g, int t, int gap,
                                            int ia, int ic, int ig, int it,
                                            int rb, int dp, bit fin);
        column_t col;
        col.cnt       = {COUNT_W'(gap), COUNT_W'(t), COUNT_W'(g), COUNT_W'(c), COUNT_W'(a)};
        col.ins       = {COUNT_W'(it), COUNT_W'(ig), COUNT_W'(ic), COUNT_W'(ia)};
        col.ref_b     = REF_W'(rb);
        col.depth     = DEPTH_W'(dp);
        col.final_col = fin;
        return col;
    endfunction

    // Appends one column to the driver's queue.
    task automatic add_column(column_t col);
        col_queue = {col_queue, col};
    endtask

    // Random column. Count profiles include wide-open values, tiny ones
    // that tie often, a single dominant allele, and a contig-wide coverage
    // level. Insertion counts are often put close to half the winning count
    // so the windowed insertion test lands on both sides of its threshold.
    function automatic column_t random_column(bit fin, int level);
        column_t col;
        int      i;
        int      mx;
        int      half;
        int      top;
        case ($urandom_range(0, 4))
            0: for (i = 0; i < NUM_BASE; i++) col.cnt[i] = COUNT_W'($urandom_range(0, 65535));
            1: for (i = 0; i < NUM_BASE; i++) col.cnt[i] = COUNT_W'($urandom_range(0, 3));
            2: begin
                for (i = 0; i < NUM_BASE; i++) col.cnt[i] = COUNT_W'($urandom_range(0, 50));
                col.cnt[$urandom_range(0, NUM_BASE - 1)] = COUNT_W'($urandom_range(51, 65535));
            end
            3: for (i = 0; i < NUM_BASE; i++) col.cnt[i] = COUNT_W'($urandom_range(level / 2, level));
            default: begin
                top = $urandom_range(0, 65535);
                for (i = 0; i < NUM_BASE; i++) begin
                    col.cnt[i] = COUNT_W'($urandom_range(0, 1) ? top : top / 2);
                end
            end
        endcase
        mx = 0;
        for (i = 0; i < NUM_BASE; i++) begin
            if (int'(col.cnt[i]) > mx) mx = col.cnt[i];
        end
        half = mx / 2;
        case ($urandom_range(0, 3))
            0: col.ins = '0;
            1: for (i = 0; i < NUM_INS; i++) col.ins[i] = COUNT_W'($urandom_range(0, 3));
            2: for (i = 0; i < NUM_INS; i++) begin
                col.ins[i] = COUNT_W'($urandom_range(half > 2 ? half - 2 : 0, half + 2));
            end
            default: for (i = 0; i < NUM_INS; i++) col.ins[i] = COUNT_W'($urandom_range(0, 65535));
        endcase
        col.ref_b     = REF_W'($urandom_range(0, 4));
        col.depth     = DEPTH_W'($urandom_range(0, 3) == 0 ? mx : $urandom_range(0, 65535));
        col.final_col = fin;
        return col;
    endfunction

    task automatic queue_contig(int len);
        int level;
        int k;
        level = $urandom_range(8, 40000);
        for (k = 0; k < len; k++) begin
            add_column(random_column(k == len - 1, level));
        end
        cols_queued += len;
        contigs_sent++;
    endtask

    task automatic wait_idle();
        while (col_queue.size() > 0 || s_tvalid || expected_reports.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_sent();
        while (col_queue.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int len;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. One-column contigs at both extremes: every count
        // at full scale (all tied, so A and inserted A win; the reference is
        // "other", so the call is an SNV), then all zero with no insertion.
        idle_pct = 20;
        add_column(make_column(65535, 65535, 65535, 65535, 65535,
                               65535, 65535, 65535, 65535, 4, 65535, 1));
        add_column(make_column(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        // Two columns: deletion wins by one read; then C, G, T tie and C wins
        // over the matching reference, with C and G tied for insertion.
        add_column(make_column(65534, 65534, 65534, 65534, 65535,
                               0, 0, 0, 1, 3, 1234, 0));
        add_column(make_column(10, 20, 20, 20, 5, 0, 7, 7, 0, 1, 77, 1));
        // Twelve columns whose winning count is always 100, so the window
        // mean is exactly 100: an insertion of 50 sits right on the threshold
        // and fails, 51 passes. Every call and every reference value shows.
        add_column(make_column(100, 99, 99, 99, 99, 50, 0, 0, 0, 1, 10, 0));
        add_column(make_column(99, 100, 99, 99, 99, 0, 51, 0, 0, 0, 11, 0));
        add_column(make_column(99, 99, 100, 99, 99, 0, 0, 51, 51, 2, 12, 0));
        add_column(make_column(99, 99, 99, 100, 99, 0, 0, 0, 65535, 4, 13, 0));
        add_column(make_column(99, 99, 99, 99, 100, 49, 50, 0, 0, 3, 14, 0));
        add_column(make_column(100, 100, 100, 100, 100, 51, 51, 51, 51, 0, 15, 0));
        add_column(make_column(0, 100, 100, 0, 100, 0, 0, 0, 50, 2, 16, 0));
        add_column(make_column(7, 0, 0, 100, 100, 1, 2, 3, 4, 3, 17, 0));
        add_column(make_column(0, 0, 0, 0, 100, 52, 0, 0, 0, 4, 18, 0));
        add_column(make_column(100, 0, 0, 0, 0, 0, 0, 60, 0, 0, 19, 0));
        add_column(make_column(99, 99, 100, 100, 99, 50, 50, 50, 50, 1, 20, 0));
        add_column(make_column(0, 0, 0, 100, 0, 0, 65535, 0, 0, 1, 65535, 1));
        cols_queued += 16;
        contigs_sent += 4;
        wait_idle();

        // Random contigs, mostly short, each with its own idle setting so
        // that some stretches run back to back and others stutter.
        while (cols_queued < 140) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            queue_contig(len);
            wait_sent();
        end

        // Backpressure: the receiver stops for a long stretch while a long
        // contig keeps coming, so the block fills and stalls its input.
        idle_pct = 0;
        hold_requests++;
        queue_contig(30);
        wait_sent();

        // Closing part with no idling on either side.
        queue_contig(12);
        queue_contig(1);
        queue_contig(3);
        wait_idle();
        repeat (SETTLE) @(posedge aclk);

        if (expected_reports.size() != 0) begin
            $error("%0d expected reports never arrived", expected_reports.size());
            err_count++;
        end
        $display("Covered %0d columns in %0d contigs, %0d reports checked.",
                 cols_accepted, contigs_sent, reports_checked);
        $display("Reports flagged: %0d SNV, %0d deletion, %0d insertion.",
                 snv_seen, del_seen, ins_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pvc_pkg.sv
hw/rtl/pvc_lane.sv
hw/rtl/pvc_argmax.sv
hw/rtl/pileup_variant_caller_unit.sv
verif/tb_pileup_variant_caller_unit.sv
